### hdl/depq_pkg.sv
package depq_pkg;

   localparam int HEAP_DEPTH = 1024;
   localparam int HEAP_AW    = $clog2(HEAP_DEPTH);
   localparam int CNT_W      = HEAP_AW + 1;
   localparam int POS_W      = CNT_W + 1;
   localparam int ID_W       = 16;
   localparam int WGT_W      = 16;
   localparam int ENT_W      = ID_W + WGT_W;
   localparam int ID_COUNT   = 65536;
   localparam int LIVE_W     = 32;
   localparam int LIVE_SH    = $clog2(LIVE_W);
   localparam int LIVE_ROWS  = ID_COUNT / LIVE_W;
   localparam int ROW_W      = $clog2(LIVE_ROWS);
   localparam int TOT_W      = 26;

   localparam logic [1:0] CMD_INSERT  = 2'd0;
   localparam logic [1:0] CMD_POP_MIN = 2'd1;
   localparam logic [1:0] CMD_POP_MAX = 2'd2;
   localparam logic [1:0] CMD_QUERY   = 2'd3;

   localparam logic [1:0] ST_ACCEPT = 2'd0;
   localparam logic [1:0] ST_VALID  = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_DROP   = 2'd3;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [ID_W-1:0]  item_id;
      logic [WGT_W-1:0] item_weight;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [TOT_W-1:0] value;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_PUSH_START,
      OP_PUSH_READ,
      OP_PUSH_MOVE,
      OP_PLACE,
      OP_READ_LAST,
      OP_DROP_START,
      OP_READ_L,
      OP_READ_R,
      OP_DROP_MOVE,
      OP_TOP_READ,
      OP_LIVE_TOP,
      OP_LIVE_ID,
      OP_POP_FIN,
      OP_INS_FIN,
      OP_SET_EMPTY,
      OP_SET_DROP,
      OP_QUERY,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      hsel;
   } dp_cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic at_root;
      logic parent_better;
      logic no_child;
      logic child_better;
      logic top_live;
      logic full;
      logic clear_done;
      logic rsp_free;
   } dp_stat_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_INS_CHECK,
      S_PUSH_START,
      S_PUSH_TEST,
      S_PUSH_EVAL,
      S_INS_FIN,
      S_CLN_TEST,
      S_CLN_LIVE,
      S_CLN_EVAL,
      S_DROP_START,
      S_DROP_TEST,
      S_DROP_READR,
      S_DROP_EVAL,
      S_POP_FIN,
      S_DONE
   } ctrl_state_type;

   function automatic logic goes_before(input logic [ENT_W-1:0] a, input logic [ENT_W-1:0] b,
                                        input logic is_max);
      return is_max ? (a > b) : (a < b);
   endfunction

endpackage

### hdl/depq_dp.sv
module depq_dp import depq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  dp_cmd_type  dp_cmd,
   output dp_stat_type dp_stat,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        rsp_ready
);

   logic [ENT_W-1:0]  lo_mem [HEAP_DEPTH];
   logic [ENT_W-1:0]  hi_mem [HEAP_DEPTH];
   logic [LIVE_W-1:0] live_mem [LIVE_ROWS];

   logic [ID_W-1:0]   id_ff;
   logic [WGT_W-1:0]  w_ff;
   logic [ENT_W-1:0]  ent_ff, ent_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff [2];
   logic [CNT_W-1:0]  cnt_in [2];
   logic [ENT_W-1:0]  top_ff [2];
   logic [ENT_W-1:0]  rdl_ff;
   logic [ENT_W-1:0]  lo_rd_ff, hi_rd_ff;
   logic [LIVE_W-1:0] lrd_ff;
   logic [ROW_W-1:0]  clr_ff;
   logic [TOT_W-1:0]  total_ff, total_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic              hs;
   logic [CNT_W-1:0]  cnt_sel;
   logic [ENT_W-1:0]  hrd, best, hi_e, lo_e;
   logic [POS_W-1:0]  lpos, rpos, cnt_x, rd_pos;
   logic [CNT_W-1:0]  bidx, wr_pos;
   logic              has_right, rd_en, wr_en, l_rd_en, l_wr_en;
   logic [ENT_W-1:0]  wr_data;
   logic [ROW_W-1:0]  l_rd_row, l_wr_row;
   logic [LIVE_W-1:0] l_wr_data;
   logic [TOT_W-1:0]  q_sum;

   assign hs      = dp_cmd.hsel;
   assign cnt_sel = cnt_ff[hs];
   assign hrd     = hs ? hi_rd_ff : lo_rd_ff;
   assign lpos    = {idx_ff, 1'b0};
   assign rpos    = {idx_ff, 1'b1};
   assign cnt_x   = {1'b0, cnt_sel};
   assign has_right = rpos <= cnt_x;
   assign best    = (has_right && goes_before(hrd, rdl_ff, hs)) ? hrd : rdl_ff;
   assign bidx    = (has_right && goes_before(hrd, rdl_ff, hs)) ? rpos[CNT_W-1:0]
                                                                : lpos[CNT_W-1:0];

   assign hi_e = (cnt_ff[1] != '0) ? top_ff[1] : '0;
   assign lo_e = (cnt_ff[0] != '0) ? top_ff[0] : '0;
   always_comb begin
      if (cnt_ff[0] != '0 && hi_e[ID_W-1:0] == lo_e[ID_W-1:0]) begin
         q_sum = total_ff - TOT_W'(hi_e[ENT_W-1:ID_W]);
      end else begin
         q_sum = total_ff - TOT_W'(hi_e[ENT_W-1:ID_W]) - TOT_W'(lo_e[ENT_W-1:ID_W]);
      end
   end

   always_comb begin
      dp_stat.cnt_zero      = cnt_sel == '0;
      dp_stat.at_root       = idx_ff == CNT_W'(1);
      dp_stat.parent_better = goes_before(ent_ff, hrd, hs);
      dp_stat.no_child      = lpos > cnt_x;
      dp_stat.child_better  = goes_before(best, ent_ff, hs);
      dp_stat.top_live      = lrd_ff[top_ff[hs][LIVE_SH-1:0]];
      dp_stat.full          = cnt_ff[0] >= CNT_W'(HEAP_DEPTH) ||
                              cnt_ff[1] >= CNT_W'(HEAP_DEPTH);
      dp_stat.clear_done    = clr_ff == ROW_W'(LIVE_ROWS - 1);
      dp_stat.rsp_free      = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      ent_in    = ent_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      total_in  = total_ff;
      res_in    = res_ff;
      rd_en     = 1'b0;
      rd_pos    = '0;
      wr_en     = 1'b0;
      wr_pos    = idx_ff;
      wr_data   = ent_ff;
      l_rd_en   = 1'b0;
      l_rd_row  = id_ff[ID_W-1:LIVE_SH];
      l_wr_en   = 1'b0;
      l_wr_row  = id_ff[ID_W-1:LIVE_SH];
      l_wr_data = lrd_ff;
      case (dp_cmd.op)
         OP_CLEAR: begin
            l_wr_en   = 1'b1;
            l_wr_row  = clr_ff;
            l_wr_data = '0;
         end
         OP_LOAD: begin
            ent_in = {req_data.item_weight, req_data.item_id};
         end
         OP_PUSH_START: begin
            cnt_in[hs] = cnt_sel + CNT_W'(1);
            idx_in     = cnt_sel + CNT_W'(1);
         end
         OP_PUSH_READ: begin
            rd_en  = 1'b1;
            rd_pos = POS_W'(idx_ff >> 1);
         end
         OP_PUSH_MOVE: begin
            wr_en   = 1'b1;
            wr_data = hrd;
            idx_in  = idx_ff >> 1;
         end
         OP_PLACE: begin
            wr_en = 1'b1;
         end
         OP_READ_LAST: begin
            rd_en  = 1'b1;
            rd_pos = cnt_x;
         end
         OP_DROP_START: begin
            ent_in     = hrd;
            cnt_in[hs] = cnt_sel - CNT_W'(1);
            idx_in     = CNT_W'(1);
         end
         OP_READ_L: begin
            rd_en  = 1'b1;
            rd_pos = lpos;
         end
         OP_READ_R: begin
            rd_en  = 1'b1;
            rd_pos = rpos;
         end
         OP_DROP_MOVE: begin
            wr_en   = 1'b1;
            wr_data = best;
            idx_in  = bidx;
         end
         OP_TOP_READ: begin
            rd_en  = 1'b1;
            rd_pos = POS_W'(1);
         end
         OP_LIVE_TOP: begin
            l_rd_en  = 1'b1;
            l_rd_row = hrd[ID_W-1:LIVE_SH];
         end
         OP_LIVE_ID: begin
            l_rd_en = 1'b1;
         end
         OP_POP_FIN: begin
            l_wr_en   = 1'b1;
            l_wr_row  = top_ff[hs][ID_W-1:LIVE_SH];
            l_wr_data = lrd_ff & ~(LIVE_W'(1) << top_ff[hs][LIVE_SH-1:0]);
            total_in  = total_ff - TOT_W'(top_ff[hs][ENT_W-1:ID_W]);
            res_in    = '{status: ST_VALID, value: TOT_W'(top_ff[hs][ID_W-1:0])};
         end
         OP_INS_FIN: begin
            l_wr_en   = 1'b1;
            l_wr_data = lrd_ff | (LIVE_W'(1) << id_ff[LIVE_SH-1:0]);
            total_in  = total_ff + TOT_W'(w_ff);
            res_in    = '{status: ST_ACCEPT, value: '0};
         end
         OP_SET_EMPTY: res_in = '{status: ST_EMPTY, value: '0};
         OP_SET_DROP:  res_in = '{status: ST_DROP, value: '0};
         OP_QUERY:     res_in = '{status: ST_VALID, value: q_sum};
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         lo_rd_ff <= lo_mem[HEAP_AW'(rd_pos - POS_W'(1))];
         hi_rd_ff <= hi_mem[HEAP_AW'(rd_pos - POS_W'(1))];
      end
      if (wr_en && !hs) begin
         lo_mem[HEAP_AW'(wr_pos - CNT_W'(1))] <= wr_data;
      end
      if (wr_en && hs) begin
         hi_mem[HEAP_AW'(wr_pos - CNT_W'(1))] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (l_rd_en) begin
         lrd_ff <= live_mem[l_rd_row];
      end
      if (l_wr_en) begin
         live_mem[l_wr_row] <= l_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      idx_ff <= idx_in;
      res_ff <= res_in;
      if (dp_cmd.op == OP_READ_R) begin
         rdl_ff <= hrd;
      end
      if (dp_cmd.op == OP_LIVE_TOP) begin
         top_ff[hs] <= hrd;
      end
      if (dp_cmd.op == OP_LOAD) begin
         id_ff <= req_data.item_id;
         w_ff  <= req_data.item_weight;
      end
      if (dp_cmd.op == OP_EMIT) begin
         rsp_data_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff[0]    <= '0;
         cnt_ff[1]    <= '0;
         total_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         total_ff <= total_in;
         if (dp_cmd.op == OP_CLEAR) begin
            clr_ff <= clr_ff + ROW_W'(1);
         end
         if (dp_cmd.op == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hdl/depq_ctrl.sv
module depq_ctrl import depq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  dp_stat_type dp_stat,
   output dp_cmd_type  dp_cmd
);

   ctrl_state_type state_ff, state_in;
   logic [1:0]     cmd_ff, cmd_in;
   logic           hsel_ff, hsel_in;
   logic           popping_ff, popping_in;
   logic           is_pop;

   assign is_pop = cmd_ff == CMD_POP_MIN || cmd_ff == CMD_POP_MAX;

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      hsel_in    = hsel_ff;
      popping_in = popping_ff;
      case (state_ff)
         S_CLEAR: if (dp_stat.clear_done) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_cmd;
               popping_in = 1'b0;
               hsel_in    = req_cmd == CMD_POP_MAX || req_cmd == CMD_QUERY;
               state_in   = (req_cmd == CMD_INSERT) ? S_INS_CHECK : S_CLN_TEST;
            end
         end
         S_INS_CHECK:  state_in = dp_stat.full ? S_DONE : S_PUSH_START;
         S_PUSH_START: state_in = S_PUSH_TEST;
         S_PUSH_TEST,
         S_PUSH_EVAL: begin
            if (state_ff == S_PUSH_TEST && !dp_stat.at_root) begin
               state_in = S_PUSH_EVAL;
            end else if (state_ff == S_PUSH_EVAL && dp_stat.parent_better) begin
               state_in = S_PUSH_TEST;
            end else if (!hsel_ff) begin
               hsel_in  = 1'b1;
               state_in = S_PUSH_START;
            end else begin
               state_in = S_INS_FIN;
            end
         end
         S_INS_FIN: state_in = S_DONE;
         S_CLN_TEST: begin
            if (!dp_stat.cnt_zero) begin
               state_in = S_CLN_LIVE;
            end else if (is_pop) begin
               state_in = S_DONE;
            end else if (hsel_ff) begin
               hsel_in = 1'b0;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CLN_LIVE: state_in = S_CLN_EVAL;
         S_CLN_EVAL: begin
            if (!dp_stat.top_live) begin
               state_in = S_DROP_START;
            end else if (is_pop) begin
               popping_in = 1'b1;
               state_in   = S_DROP_START;
            end else if (hsel_ff) begin
               hsel_in  = 1'b0;
               state_in = S_CLN_TEST;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DROP_START: state_in = S_DROP_TEST;
         S_DROP_TEST,
         S_DROP_EVAL: begin
            if (state_ff == S_DROP_TEST && !dp_stat.no_child) begin
               state_in = S_DROP_READR;
            end else if (state_ff == S_DROP_EVAL && dp_stat.child_better) begin
               state_in = S_DROP_TEST;
            end else begin
               state_in = popping_ff ? S_POP_FIN : S_CLN_TEST;
            end
         end
         S_DROP_READR: state_in = S_DROP_EVAL;
         S_POP_FIN:    state_in = S_DONE;
         S_DONE:       if (dp_stat.rsp_free) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      dp_cmd.hsel = hsel_ff;
      dp_cmd.op   = OP_NONE;
      case (state_ff)
         S_CLEAR: dp_cmd.op = OP_CLEAR;
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) dp_cmd.op = OP_LOAD;
         end
         S_INS_CHECK:  dp_cmd.op = dp_stat.full ? OP_SET_DROP : OP_LIVE_ID;
         S_PUSH_START: dp_cmd.op = OP_PUSH_START;
         S_PUSH_TEST:  dp_cmd.op = dp_stat.at_root ? OP_PLACE : OP_PUSH_READ;
         S_PUSH_EVAL:  dp_cmd.op = dp_stat.parent_better ? OP_PUSH_MOVE : OP_PLACE;
         S_INS_FIN:    dp_cmd.op = OP_INS_FIN;
         S_CLN_TEST: begin
            if (!dp_stat.cnt_zero) begin
               dp_cmd.op = OP_TOP_READ;
            end else if (is_pop) begin
               dp_cmd.op = OP_SET_EMPTY;
            end else if (!hsel_ff) begin
               dp_cmd.op = OP_QUERY;
            end
         end
         S_CLN_LIVE: dp_cmd.op = OP_LIVE_TOP;
         S_CLN_EVAL: begin
            if (!dp_stat.top_live || is_pop) begin
               dp_cmd.op = OP_READ_LAST;
            end else if (!hsel_ff) begin
               dp_cmd.op = OP_QUERY;
            end
         end
         S_DROP_START: dp_cmd.op = OP_DROP_START;
         S_DROP_TEST:  dp_cmd.op = dp_stat.no_child ? OP_PLACE : OP_READ_L;
         S_DROP_READR: dp_cmd.op = OP_READ_R;
         S_DROP_EVAL:  dp_cmd.op = dp_stat.child_better ? OP_DROP_MOVE : OP_PLACE;
         S_POP_FIN:    dp_cmd.op = OP_POP_FIN;
         S_DONE:       if (dp_stat.rsp_free) dp_cmd.op = OP_EMIT;
         default:      dp_cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         cmd_ff     <= CMD_INSERT;
         hsel_ff    <= 1'b0;
         popping_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmd_ff     <= cmd_in;
         hsel_ff    <= hsel_in;
         popping_ff <= popping_in;
      end
   end

endmodule

### hdl/double_ended_priority_queue.sv
// Double-ended priority queue: a min-heap and a max-heap of (id, weight)
// entries with lazy deletion through a per-id live map.
// Request channel req_valid/req_ready/req_data carries one command per
// transfer: insert, pop minimum, pop maximum or trimmed-sum query.
// Response channel rsp_valid/rsp_ready/rsp_data returns exactly one result
// per command, in command order.
// One command is in flight at a time. An insert runs a sift-up in each heap;
// a pop or query removes heap tops, including stale tops discarded on the
// way. The single-port heap memories allow one access per cycle. The result
// sits in an output register; while it waits for rsp_ready the next command
// can be accepted and worked on, and its result waits until the output
// register is free.
// After reset the live map is swept clear, one 32-bit row per cycle, over all
// 2048 rows; req_ready stays low until the sweep is done.
module double_ended_priority_queue import depq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   depq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_data.cmd),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   depq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_ready (rsp_ready)
   );

endmodule

### hdl/depq_checker.sv
module depq_checker import depq_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !req_ready && !rsp_valid)
      else $error("ready or response after reset");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second command taken while one in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed before transfer");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_ACCEPT || rsp_data.status == ST_EMPTY ||
                     rsp_data.status == ST_DROP)) |-> rsp_data.value == '0)
      else $error("non-zero value with status that carries none");

endmodule

bind double_ended_priority_queue depq_checker u_depq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### bench/double_ended_priority_queue_checker.sv
`timescale 1ns / 100ps
module double_ended_priority_queue_checker import depq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);

   logic [ENT_W-1:0] min_heap [1:HEAP_DEPTH];
   logic [ENT_W-1:0] max_heap [1:HEAP_DEPTH];
   int               min_size;
   int               max_size;
   bit               id_live [ID_COUNT];
   logic [TOT_W-1:0] weight_sum;
   rsp_type          expected_rsp [$];

   function automatic bit ahead(logic [ENT_W-1:0] a, logic [ENT_W-1:0] b, bit is_max);
      return is_max ? (a > b) : (a < b);
   endfunction

   task automatic heap_insert(bit is_max, logic [ENT_W-1:0] e);
      int               i;
      logic [ENT_W-1:0] t;
      if (is_max) begin
         max_size++;
         i = max_size;
         max_heap[i] = e;
         while (i > 1 && ahead(max_heap[i], max_heap[i/2], 1)) begin
            t = max_heap[i]; max_heap[i] = max_heap[i/2]; max_heap[i/2] = t;
            i = i / 2;
         end
      end else begin
         min_size++;
         i = min_size;
         min_heap[i] = e;
         while (i > 1 && ahead(min_heap[i], min_heap[i/2], 0)) begin
            t = min_heap[i]; min_heap[i] = min_heap[i/2]; min_heap[i/2] = t;
            i = i / 2;
         end
      end
   endtask

   task automatic heap_remove_top(bit is_max);
      int               i;
      int               c;
      logic [ENT_W-1:0] t;
      if (is_max) begin
         max_heap[1] = max_heap[max_size];
         max_size--;
         i = 1;
         forever begin
            c = 2 * i;
            if (c > max_size) break;
            if (c + 1 <= max_size && ahead(max_heap[c+1], max_heap[c], 1)) c++;
            if (!ahead(max_heap[c], max_heap[i], 1)) break;
            t = max_heap[i]; max_heap[i] = max_heap[c]; max_heap[c] = t;
            i = c;
         end
      end else begin
         min_heap[1] = min_heap[min_size];
         min_size--;
         i = 1;
         forever begin
            c = 2 * i;
            if (c > min_size) break;
            if (c + 1 <= min_size && ahead(min_heap[c+1], min_heap[c], 0)) c++;
            if (!ahead(min_heap[c], min_heap[i], 0)) break;
            t = min_heap[i]; min_heap[i] = min_heap[c]; min_heap[c] = t;
            i = c;
         end
      end
   endtask

   task automatic discard_stale(bit is_max);
      if (is_max)
         while (max_size > 0 && !id_live[max_heap[1][ID_W-1:0]]) heap_remove_top(1);
      else
         while (min_size > 0 && !id_live[min_heap[1][ID_W-1:0]]) heap_remove_top(0);
   endtask

   task automatic pop_end(bit is_max, output rsp_type r);
      logic [ENT_W-1:0] e;
      discard_stale(is_max);
      if ((is_max ? max_size : min_size) == 0) begin
         r.status = ST_EMPTY;
         r.value  = '0;
      end else begin
         e = is_max ? max_heap[1] : min_heap[1];
         heap_remove_top(is_max);
         id_live[e[ID_W-1:0]] = 0;
         weight_sum = weight_sum - TOT_W'(e[ENT_W-1:ID_W]);
         r.status = ST_VALID;
         r.value  = TOT_W'(e[ID_W-1:0]);
      end
   endtask

   task automatic predict_command(req_type q);
      rsp_type          r;
      logic [ENT_W-1:0] hi;
      logic [ENT_W-1:0] lo;
      r = '0;
      case (q.cmd)
         CMD_INSERT: begin
            if (min_size >= HEAP_DEPTH || max_size >= HEAP_DEPTH) begin
               r.status = ST_DROP;
            end else begin
               heap_insert(0, {q.item_weight, q.item_id});
               heap_insert(1, {q.item_weight, q.item_id});
               id_live[q.item_id] = 1;
               weight_sum = weight_sum + TOT_W'(q.item_weight);
               r.status = ST_ACCEPT;
            end
         end
         CMD_POP_MIN: pop_end(0, r);
         CMD_POP_MAX: pop_end(1, r);
         default: begin
            discard_stale(1);
            discard_stale(0);
            hi = max_size > 0 ? max_heap[1] : '0;
            lo = min_size > 0 ? min_heap[1] : '0;
            r.status = ST_VALID;
            if (min_size > 0 && hi[ID_W-1:0] == lo[ID_W-1:0])
               r.value = weight_sum - TOT_W'(hi[ENT_W-1:ID_W]);
            else
               r.value = weight_sum - TOT_W'(hi[ENT_W-1:ID_W]) - TOT_W'(lo[ENT_W-1:ID_W]);
         end
      endcase
      expected_rsp.push_back(r);
   endtask

   task automatic report(string what, rsp_type got, rsp_type want);
      $display("mismatch (%s): got status %0d value %0d, want status %0d value %0d",
               what, got.status, got.value, want.status, want.value);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      min_size   = 0;
      max_size   = 0;
      weight_sum = '0;
   end

   assign pending = expected_rsp.size();

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) predict_command(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report("unexpected transfer", rsp_data, '0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status) report("status", rsp_data, want);
               else if (rsp_data.value !== want.value) report("value", rsp_data, want);
            end
         end
      end
   end

endmodule

### bench/double_ended_priority_queue_test.sv
`timescale 1ns / 100ps
module double_ended_priority_queue_test import depq_pkg::*;;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   bit      hold_off;

   double_ended_priority_queue dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   double_ended_priority_queue_checker checker_inst (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .fail_count, .pending
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("timeout");
      $display("** double_ended_priority_queue: FAILED **");
      $finish;
   end

   // issue one command, holding it until the transfer
   task automatic send(logic [1:0] cmd, logic [15:0] id, logic [15:0] wgt);
      req_valid <= 1;
      req_data  <= '{cmd: cmd, item_id: id, item_weight: wgt};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic gap();
      int n;
      n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_random(int id_span);
      int k;
      logic [1:0] c;
      k = $urandom_range(0, 99);
      c = k < 45 ? CMD_INSERT : k < 68 ? CMD_POP_MIN : k < 90 ? CMD_POP_MAX : CMD_QUERY;
      send(c, id_span > 0 ? 16'($urandom_range(0, id_span)) : 16'($urandom),
           $urandom_range(0, 7) == 0 ? 16'($urandom_range(0, 3)) : 16'($urandom));
   endtask

   // receiver stall pattern, plus one long hold-off
   initial begin
      int phase;
      rsp_ready <= 0;
      phase = 0;
      forever begin
         @(posedge clock);
         phase++;
         if (hold_off) rsp_ready <= 0;
         else if (phase % 400 < 100) rsp_ready <= 1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   initial begin
      int n;
      int w;
      req_valid <= 0;
      req_data  <= '0;
      hold_off  = 0;
      reset <= 1;
      repeat (7) @(posedge clock);
      reset <= 0;

      // directed
      send(CMD_POP_MIN, 0, 0);
      send(CMD_POP_MAX, 0, 0);
      send(CMD_QUERY, 0, 0);
      send(CMD_INSERT, 16'hFFFF, 16'hFFFF);
      send(CMD_QUERY, 0, 0);
      send(CMD_INSERT, 0, 0);
      send(CMD_INSERT, 16'h5555, 16'hAAAA);
      send(CMD_INSERT, 16'hAAAA, 16'hAAAA);
      send(CMD_INSERT, 16'h5555, 16'h0001);
      send(CMD_QUERY, 0, 0);
      send(CMD_POP_MAX, 0, 0);
      send(CMD_POP_MIN, 0, 0);
      send(CMD_QUERY, 0, 0);
      send(CMD_POP_MIN, 0, 0);
      send(CMD_POP_MAX, 0, 0);
      send(CMD_POP_MIN, 0, 0);
      send(CMD_POP_MAX, 0, 0);
      send(CMD_QUERY, 0, 0);

      // long receiver hold-off while offering more commands
      fork
         begin
            hold_off = 1;
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         repeat (6) send_random(40);
      join

      // random, half of it in a small id space to exercise duplicates and stale tops
      for (n = 0; n < 120; n++) begin
         send_random(n % 60 < 30 ? 60 : 0);
         gap();
      end

      // fill the heaps to overflow, then pop from both ends
      for (n = 0; n < HEAP_DEPTH + 4; n++) begin
         w = $urandom_range(0, 1);
         send(w ? CMD_INSERT : CMD_INSERT, 16'($urandom), 16'hFFFF - 16'($urandom_range(0, 9)));
      end
      send(CMD_QUERY, 0, 0);
      for (n = 0; n < 150; n++) send(n % 2 ? CMD_POP_MIN : CMD_POP_MAX, 0, 0);
      send(CMD_QUERY, 0, 0);
      req_valid <= 0;

      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("** double_ended_priority_queue: PASSED **");
      else
         $display("** double_ended_priority_queue: FAILED **");
      $finish;
   end

endmodule
